[hw/rtl/stq_pkg.sv]
// shared types and constants of the sorted timer queue
package stq_pkg;

	localparam int FIELD_BITS = 48;
	localparam int ID_BITS    = 4;
	localparam int OP_BITS    = 2;

	// request operations
	localparam logic [OP_BITS-1:0] OP_START_ABS = 2'd0;
	localparam logic [OP_BITS-1:0] OP_START_REL = 2'd1;
	localparam logic [OP_BITS-1:0] OP_STOP      = 2'd2;
	localparam logic [OP_BITS-1:0] OP_RUN       = 2'd3;

	// most timers popped by one run request
	localparam int RESULT_CAP = 16;
	localparam int CNT_BITS   = $clog2(RESULT_CAP + 1);

	typedef struct packed {
		logic [OP_BITS-1:0]    operation;
		logic [ID_BITS-1:0]    timer_id;
		logic [FIELD_BITS-1:0] time_value;
		logic [FIELD_BITS-1:0] now;
	} req_t;

	typedef struct packed {
		logic                  fired_valid;
		logic [ID_BITS-1:0]    fired_id;
		logic [FIELD_BITS-1:0] fired_deadline;
		logic                  last;
		logic                  next_valid;
		logic [FIELD_BITS-1:0] next_deadline;
		logic                  next_overdue;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic remove;
		logic insert;
		logic pop;
		logic load_out;
		logic fired;
		logic last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic head_due;
		logic second_due;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/stq_stream_if.sv]
// valid/ready stream channel carrying one word of type T
interface stq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/stq_ctrl.sv]
// controller state machine of the sorted timer queue
module stq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [stq_pkg::OP_BITS-1:0]      in_op,
	output logic                             in_ready,
	input  stq_pkg::status_t                 st,
	output stq_pkg::cmd_t                    cmd
);
	import stq_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REMOVE = 3'd1;
	localparam logic [2:0] ST_INSERT = 3'd2;
	localparam logic [2:0] ST_REPORT = 3'd3;
	localparam logic [2:0] ST_RUN    = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [OP_BITS-1:0]  op_q, op_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					op_d      = in_op;
					cnt_d     = '0;
					state_d   = (in_op == OP_RUN) ? ST_RUN : ST_REMOVE;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = (op_q == OP_STOP) ? ST_REPORT : ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_REPORT;
			end
			ST_REPORT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.last     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					if (st.head_due && cnt_q < CNT_BITS'(RESULT_CAP)) begin
						// pop the head; last when the following head will not pop
						cmd.pop   = 1'b1;
						cmd.fired = 1'b1;
						cmd.last  = !(st.second_due && cnt_q < CNT_BITS'(RESULT_CAP - 1));
						cnt_d     = cnt_q + 1'b1;
						if (cmd.last) begin
							state_d = ST_IDLE;
						end
					end else begin
						// nothing expired
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_START_ABS;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[hw/rtl/stq_datapath.sv]
// sorted cell chain, request registers and output register
module stq_datapath #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stq_pkg::req_t     req_data,
	input  stq_pkg::cmd_t     cmd,
	output stq_pkg::status_t  st,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output stq_pkg::rsp_t     rsp_data
);
	import stq_pkg::*;

	// cells, packed at the low end in deadline order
	logic [TIMER_SLOTS-1:0] cell_valid_q;
	logic [ID_BITS-1:0]     cell_id_q       [TIMER_SLOTS];
	logic [TIME_BITS-1:0]   cell_deadline_q [TIMER_SLOTS];

	// latched request
	logic [ID_BITS-1:0]   req_id_q;
	logic [TIME_BITS-1:0] req_deadline_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] tv;
	logic [TIME_BITS-1:0] now_in;

	// neighbor views and per-cell controls
	logic [TIMER_SLOTS-1:0] dn_valid;
	logic [ID_BITS-1:0]     dn_id       [TIMER_SLOTS];
	logic [TIME_BITS-1:0]   dn_deadline [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] up_valid;
	logic [ID_BITS-1:0]     up_id       [TIMER_SLOTS];
	logic [TIME_BITS-1:0]   up_deadline [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] match;
	logic [TIMER_SLOTS-1:0] shift_dn;
	logic [TIMER_SLOTS-1:0] shift_up;
	logic [TIMER_SLOTS-1:0] take_new;
	logic                   full;

	logic [TIMER_SLOTS-1:0] valid_d;
	logic [ID_BITS-1:0]     id_d       [TIMER_SLOTS];
	logic [TIME_BITS-1:0]   deadline_d [TIMER_SLOTS];

	logic                 sel_valid;
	logic [TIME_BITS-1:0] sel_deadline;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	assign full   = cell_valid_q[TIMER_SLOTS-1];
	assign tv     = TIME_BITS'(req_data.time_value);
	assign now_in = TIME_BITS'(req_data.now);

	// request registers, deadline sum wraps at the time width
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_id_q       <= req_data.timer_id;
			now_q          <= now_in;
			req_deadline_q <= (req_data.operation == OP_START_ABS) ? tv : tv + now_in;
		end
	end

	// per-cell shift decisions
	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		assign match[i]    = cell_valid_q[i] && (cell_id_q[i] == req_id_q);
		assign shift_dn[i] = cmd.pop || (cmd.remove && (|match[i:0]));
		assign shift_up[i] = cmd.insert && !full
			&& (!cell_valid_q[i] || (cell_deadline_q[i] > req_deadline_q));

		if (i + 1 < TIMER_SLOTS) begin : g_dn
			assign dn_valid[i]    = cell_valid_q[i+1];
			assign dn_id[i]       = cell_id_q[i+1];
			assign dn_deadline[i] = cell_deadline_q[i+1];
		end else begin : g_dn_end
			assign dn_valid[i]    = 1'b0;
			assign dn_id[i]       = '0;
			assign dn_deadline[i] = '0;
		end

		if (i == 0) begin : g_up_head
			assign take_new[i]    = shift_up[i];
			assign up_valid[i]    = 1'b0;
			assign up_id[i]       = '0;
			assign up_deadline[i] = '0;
		end else begin : g_up
			assign take_new[i]    = shift_up[i] && !shift_up[i-1];
			assign up_valid[i]    = cell_valid_q[i-1];
			assign up_id[i]       = cell_id_q[i-1];
			assign up_deadline[i] = cell_deadline_q[i-1];
		end
	end

	// next cell contents
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			valid_d[i]    = cell_valid_q[i];
			id_d[i]       = cell_id_q[i];
			deadline_d[i] = cell_deadline_q[i];
			if (shift_dn[i]) begin
				valid_d[i]    = dn_valid[i];
				id_d[i]       = dn_id[i];
				deadline_d[i] = dn_deadline[i];
			end else if (take_new[i]) begin
				valid_d[i]    = 1'b1;
				id_d[i]       = req_id_q;
				deadline_d[i] = req_deadline_q;
			end else if (shift_up[i]) begin
				valid_d[i]    = up_valid[i];
				id_d[i]       = up_id[i];
				deadline_d[i] = up_deadline[i];
			end
		end
	end

	// cell valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= '0;
		end else if (cmd.remove || cmd.pop || cmd.insert) begin
			cell_valid_q <= valid_d;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (cmd.remove || cmd.pop || cmd.insert) begin
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				cell_id_q[i]       <= id_d[i];
				cell_deadline_q[i] <= deadline_d[i];
			end
		end
	end

	// status toward the controller
	assign st.head_due   = cell_valid_q[0] && (cell_deadline_q[0] <= now_q);
	assign st.second_due = dn_valid[0] && (dn_deadline[0] <= now_q);
	assign st.out_free   = !rsp_valid_q || rsp_ready;

	// head after this result: the second cell when the head pops
	assign sel_valid    = cmd.fired ? dn_valid[0] : cell_valid_q[0];
	assign sel_deadline = cmd.fired ? dn_deadline[0] : cell_deadline_q[0];

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.fired_valid    <= cmd.fired;
			rsp_q.fired_id       <= cmd.fired ? cell_id_q[0] : '0;
			rsp_q.fired_deadline <= cmd.fired ? FIELD_BITS'(cell_deadline_q[0]) : '0;
			rsp_q.last           <= cmd.last;
			rsp_q.next_valid     <= sel_valid;
			rsp_q.next_deadline  <= sel_valid ? FIELD_BITS'(sel_deadline) : '0;
			rsp_q.next_overdue   <= sel_valid && (sel_deadline <= now_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[hw/rtl/sorted_timer_queue.sv]
// Sorted deadline timer queue: up to TIMER_SLOTS armed timers, each named by a
// 4-bit id, held in a chain of cells in deadline order (equal deadlines keep
// arrival order). A request word is taken while the queue is idle; a start then
// removes the id and inserts it again, and its single result word is loaded
// after that; a stop only removes the id before its result word is loaded. A
// run pops one expired timer per cycle from the head of the chain while the
// output word is free, one result word per timer (at most sixteen per run), or
// a single word with no fired timer when nothing expired. The chain shifts by
// one cell per operation; a stalled output word holds the controller in place.
// Deadlines and sums wrap at TIME_BITS bits. Reset empties the queue at once.
module sorted_timer_queue #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	stq_stream_if.sink   req,
	stq_stream_if.source rsp
);
	import stq_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    in_ready;
	logic    rsp_valid;
	rsp_t    rsp_data;
	req_t    req_data;

	assign req_data  = req.data;
	assign req.ready = in_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

	// control
	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req_data.operation),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// cell chain and output word
	stq_datapath #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data)
	);

endmodule
